FILE: sv/rec_pkg.sv
// Shared types and constants for the rational equality comparator.
// Holds the controller-to-datapath command and datapath-to-controller status structs; no dependencies.
package rec_pkg;

    localparam int DEF_WIDTH = 32;
    localparam int FIELD_W   = 32;

    typedef struct packed {
        logic load_in;
        logic gcd_init;
        logic gcd_step;
        logic gcd_fin;
        logic div_init_n;
        logic div_init_d;
        logic div_step;
        logic store_n;
        logic store_d;
        logic next_frac;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
        logic skip;
        logic out_busy;
    } t_sts;

endpackage

FILE: sv/rec_ctrl.sv
// Sequencing state machine of the rational equality comparator.
// Depends on rec_pkg for the command and status structs.
module rec_ctrl
    import rec_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_GINIT = 4'd1;
    localparam logic [3:0] S_GRUN  = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_NINIT = 4'd4;
    localparam logic [3:0] S_NRUN  = 4'd5;
    localparam logic [3:0] S_DINIT = 4'd6;
    localparam logic [3:0] S_DRUN  = 4'd7;
    localparam logic [3:0] S_FEND  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_second;
    logic       n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_second      = 1'b0;
                    n_state       = S_GINIT;
                end
            end
            S_GINIT: begin
                o_cmd.gcd_init = 1'b1;
                n_state        = S_GRUN;
            end
            S_GRUN: begin
                if (i_sts.gcd_done) begin
                    o_cmd.gcd_fin = 1'b1;
                    n_state       = S_CHK;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_CHK: begin
                n_state = i_sts.skip ? S_FEND : S_NINIT;
            end
            S_NINIT: begin
                o_cmd.div_init_n = 1'b1;
                n_state          = S_NRUN;
            end
            S_NRUN: begin
                if (i_sts.div_done) begin
                    o_cmd.store_n = 1'b1;
                    n_state       = S_DINIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DINIT: begin
                o_cmd.div_init_d = 1'b1;
                n_state          = S_DRUN;
            end
            S_DRUN: begin
                if (i_sts.div_done) begin
                    o_cmd.store_d = 1'b1;
                    n_state       = S_FEND;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FEND: begin
                if (!r_second) begin
                    o_cmd.next_frac = 1'b1;
                    n_second        = 1'b1;
                    n_state         = S_GINIT;
                end else if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: sv/rec_dp.sv
// Datapath of the rational equality comparator: sign step, binary GCD,
// restoring divider and the output register. Depends on rec_pkg.
module rec_dp
    import rec_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic signed [FIELD_W-1:0] i_a_num,
    input  logic signed [FIELD_W-1:0] i_a_den,
    input  logic signed [FIELD_W-1:0] i_b_num,
    input  logic signed [FIELD_W-1:0] i_b_den,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic                      o_equal
);

    localparam int K_W   = $clog2(WIDTH);
    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] s_an_in;
    logic [WIDTH-1:0] s_ad_in;
    logic [WIDTH-1:0] s_bn_in;
    logic [WIDTH-1:0] s_bd_in;

    generate
        if (WIDTH > FIELD_W) begin : g_ext
            assign s_an_in = {{(WIDTH - FIELD_W){i_a_num[FIELD_W-1]}}, i_a_num};
            assign s_ad_in = {{(WIDTH - FIELD_W){i_a_den[FIELD_W-1]}}, i_a_den};
            assign s_bn_in = {{(WIDTH - FIELD_W){i_b_num[FIELD_W-1]}}, i_b_num};
            assign s_bd_in = {{(WIDTH - FIELD_W){i_b_den[FIELD_W-1]}}, i_b_den};
        end else begin : g_trunc
            assign s_an_in = i_a_num[WIDTH-1:0];
            assign s_ad_in = i_a_den[WIDTH-1:0];
            assign s_bn_in = i_b_num[WIDTH-1:0];
            assign s_bd_in = i_b_den[WIDTH-1:0];
        end
    endgenerate

    logic [WIDTH-1:0] r_num;
    logic [WIDTH-1:0] r_den;
    logic [WIDTH-1:0] r_bn;
    logic [WIDTH-1:0] r_bd;
    logic [WIDTH-1:0] r_an;
    logic [WIDTH-1:0] r_ad;
    logic [WIDTH-1:0] r_ga;
    logic [WIDTH-1:0] r_gb;
    logic [K_W-1:0]   r_k;
    logic [WIDTH-1:0] r_g;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic             r_equal;

    logic [WIDTH-1:0] s_num_mag;
    logic [WIDTH-1:0] s_den_mag;
    logic [WIDTH:0]   s_rem_sh;
    logic [WIDTH:0]   s_sub;
    logic             s_ge;
    logic [WIDTH-1:0] s_quo_neg;

    assign s_num_mag = r_num[WIDTH-1] ? (~r_num + 1'b1) : r_num;
    assign s_den_mag = r_den[WIDTH-1] ? (~r_den + 1'b1) : r_den;
    assign s_rem_sh  = {r_rem, r_quo[WIDTH-1]};
    assign s_sub     = s_rem_sh - {1'b0, r_g};
    assign s_ge      = !s_sub[WIDTH];
    assign s_quo_neg = ~r_quo + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_num <= s_ad_in[WIDTH-1] ? (~s_an_in + 1'b1) : s_an_in;
            r_den <= s_ad_in[WIDTH-1] ? (~s_ad_in + 1'b1) : s_ad_in;
            r_bn  <= s_bn_in;
            r_bd  <= s_bd_in;
        end else if (i_cmd.next_frac) begin
            r_an  <= r_num;
            r_ad  <= r_den;
            r_num <= r_bd[WIDTH-1] ? (~r_bn + 1'b1) : r_bn;
            r_den <= r_bd[WIDTH-1] ? (~r_bd + 1'b1) : r_bd;
        end else if (i_cmd.store_n) begin
            r_num <= r_num[WIDTH-1] ? s_quo_neg : r_quo;
        end else if (i_cmd.store_d) begin
            r_den <= r_den[WIDTH-1] ? s_quo_neg : r_quo;
        end

        if (i_cmd.gcd_init) begin
            r_ga <= s_num_mag;
            r_gb <= s_den_mag;
            r_k  <= '0;
        end else if (i_cmd.gcd_step) begin
            if (!r_ga[0] && !r_gb[0]) begin
                r_ga <= r_ga >> 1;
                r_gb <= r_gb >> 1;
                r_k  <= r_k + 1'b1;
            end else if (!r_ga[0]) begin
                r_ga <= r_ga >> 1;
            end else if (!r_gb[0]) begin
                r_gb <= r_gb >> 1;
            end else if (r_ga >= r_gb) begin
                r_ga <= r_ga - r_gb;
            end else begin
                r_gb <= r_gb - r_ga;
            end
        end

        if (i_cmd.gcd_fin) begin
            r_g <= (r_ga | r_gb) << r_k;
        end

        if (i_cmd.div_init_n || i_cmd.div_init_d) begin
            r_rem <= '0;
            r_quo <= i_cmd.div_init_n ? s_num_mag : s_den_mag;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= s_ge ? s_sub[WIDTH-1:0] : s_rem_sh[WIDTH-1:0];
            r_quo <= {r_quo[WIDTH-2:0], s_ge};
            r_cnt <= r_cnt + 1'b1;
        end

        if (i_cmd.out_load) begin
            r_equal <= (r_an == r_num) && (r_ad == r_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.gcd_done = (r_ga == '0) || (r_gb == '0);
    assign o_sts.div_done = (r_cnt == CNT_W'(WIDTH));
    assign o_sts.skip     = (r_g == '0) || (r_g == {1'b1, {(WIDTH - 1){1'b0}}});
    assign o_sts.out_busy = r_out_valid && i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_equal     = r_equal;

endmodule

FILE: sv/rational_equality_compare.sv
// Top level of the rational equality comparator; joins rec_ctrl and rec_dp.
// Depends on rec_pkg, rec_ctrl and rec_dp.
//
// Each transfer carries two signed fractions; each fraction is brought to
// canonical form (non-negative denominator, divided by the GCD of its parts,
// with wrapping negation) and one result transfer reports whether the two
// forms match. Work is done one item at a time. After the load, each fraction
// runs the binary GCD steps, a check and, unless the GCD is zero or the sign
// bit alone, a division of its numerator and then of its denominator by the
// GCD, on the bit-serial GCD unit and the one-bit per cycle restoring divider.
// A finished result waits in an output register while the next input is
// accepted; the next result is held back until that one is gone.
module rational_equality_compare
    import rec_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [FIELD_W-1:0] i_a_num,
    input  logic signed [FIELD_W-1:0] i_a_den,
    input  logic signed [FIELD_W-1:0] i_b_num,
    input  logic signed [FIELD_W-1:0] i_b_den,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_equal
);

    t_cmd s_cmd;
    t_sts s_sts;

    rec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    rec_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_a_num     (i_a_num),
        .i_a_den     (i_a_den),
        .i_b_num     (i_b_num),
        .i_b_den     (i_b_den),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_equal     (o_equal)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Input accepted but the block did not go busy.");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(s_cmd))
        else $error("More than one datapath command in a cycle.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.out_load |-> !(o_out_valid && i_out_stall))
        else $error("Output register loaded while its result still waits.");

    a_no_div_on_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.div_init_n |-> !s_sts.skip)
        else $error("Division started with a GCD that must be skipped.");

endmodule

FILE: tb/rational_equality_compare_test.sv
// Self-checking testbench for rational_equality_compare: drives fraction pairs,
// predicts the equality bit from its own reduction logic and checks every result.
// Depends on rec_pkg and the rational_equality_compare RTL only.
module rational_equality_compare_test;
    import rec_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH        = DEF_WIDTH;
    localparam int HOLD_CYCLES  = 800;
    localparam int DRAIN_CYCLES = 300;

    typedef logic signed [FIELD_W-1:0] t_field;
    typedef logic [WIDTH-1:0]          t_val;

    typedef struct {
        t_field a_num;
        t_field a_den;
        t_field b_num;
        t_field b_den;
    } t_fracs;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} t_stall_mode;
    typedef enum {
        SHAPE_NOISE, SHAPE_SCALED, SHAPE_NEAR, SHAPE_CORNER, SHAPE_ZERO, SHAPE_SAME
    } t_shape;

    localparam t_field MIN_F = 32'sh8000_0000;
    localparam t_field MAX_F = 32'sh7fff_ffff;
    localparam t_val   SIGN_BIT = {1'b1, {(WIDTH - 1){1'b0}}};
    localparam t_field CORNER_VALUES [8] = '{
        32'sh0000_0000, 32'sh0000_0001, 32'shffff_ffff, 32'sh8000_0000,
        32'sh7fff_ffff, 32'sh8000_0001, 32'sh4000_0000, 32'shc000_0000
    };

    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_stall;
    t_field i_a_num;
    t_field i_a_den;
    t_field i_b_num;
    t_field i_b_den;
    logic   o_out_valid;
    logic   i_out_stall;
    logic   o_equal;

    bit          equal_expected_q[$];
    int          fail_count;
    int          sent_count;
    int          equal_seen;
    int          unequal_seen;
    int          hold_seq;
    t_stall_mode stall_mode;

    rational_equality_compare dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_a_num     (i_a_num),
        .i_a_den     (i_a_den),
        .i_b_num     (i_b_num),
        .i_b_den     (i_b_den),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_equal     (o_equal)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_val wrap_neg(t_val v);
        return t_val'(0) - v;
    endfunction

    function automatic t_val magnitude(t_val v);
        return v[WIDTH-1] ? wrap_neg(v) : v;
    endfunction

    function automatic t_val euclid_gcd(t_val a, t_val b);
        t_val r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic t_val signed_div(t_val v, t_val g);
        t_val q;
        q = magnitude(v) / g;
        return v[WIDTH-1] ? wrap_neg(q) : q;
    endfunction

    function automatic void reduce_fraction(inout t_val n, inout t_val d);
        t_val g;
        if (d[WIDTH-1]) begin
            n = wrap_neg(n);
            d = wrap_neg(d);
        end
        g = euclid_gcd(magnitude(n), magnitude(d));
        if (g != 0 && g != SIGN_BIT) begin
            n = signed_div(n, g);
            d = signed_div(d, g);
        end
    endfunction

    function automatic bit predict_equal(t_fracs f);
        t_val an, ad, bn, bd;
        an = t_val'(f.a_num);
        ad = t_val'(f.a_den);
        bn = t_val'(f.b_num);
        bd = t_val'(f.b_den);
        reduce_fraction(an, ad);
        reduce_fraction(bn, bd);
        return (an == bn) && (ad == bd);
    endfunction

    function automatic t_field random_scaled();
        t_field v;
        v = t_field'($urandom >> $urandom_range(0, 31));
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic t_field random_factor();
        t_field k;
        k = t_field'($urandom_range(1, 1000));
        return $urandom_range(0, 1) ? -k : k;
    endfunction

    function automatic t_shape pick_shape();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return SHAPE_NOISE;
        if (roll < 50) return SHAPE_SCALED;
        if (roll < 65) return SHAPE_NEAR;
        if (roll < 80) return SHAPE_CORNER;
        if (roll < 90) return SHAPE_ZERO;
        return SHAPE_SAME;
    endfunction

    function automatic t_fracs random_fracs();
        t_fracs f;
        t_field n, d, k1, k2;
        t_shape shape;
        shape = pick_shape();
        n  = random_scaled() >>> $urandom_range(0, 20);
        d  = random_scaled() >>> $urandom_range(0, 20);
        k1 = random_factor();
        k2 = random_factor();
        f.a_num = n * k1;
        f.a_den = d * k1;
        f.b_num = n * k2;
        f.b_den = d * k2;
        case (shape)
            SHAPE_NOISE: begin
                f.a_num = t_field'($urandom);
                f.a_den = t_field'($urandom);
                f.b_num = t_field'($urandom);
                f.b_den = t_field'($urandom);
            end
            SHAPE_SCALED: begin
            end
            SHAPE_NEAR: begin
                if ($urandom_range(0, 1)) begin
                    f.b_num = f.b_num + ($urandom_range(0, 1) ? 1 : -1);
                end else begin
                    f.b_den = f.b_den + ($urandom_range(0, 1) ? 1 : -1);
                end
            end
            SHAPE_CORNER: begin
                f.a_num = $urandom_range(0, 2) ? CORNER_VALUES[$urandom_range(0, 7)] : n;
                f.a_den = $urandom_range(0, 2) ? CORNER_VALUES[$urandom_range(0, 7)] : d;
                f.b_num = $urandom_range(0, 2) ? CORNER_VALUES[$urandom_range(0, 7)] : n;
                f.b_den = $urandom_range(0, 2) ? CORNER_VALUES[$urandom_range(0, 7)] : d;
            end
            SHAPE_ZERO: begin
                if ($urandom_range(0, 1)) f.a_den = 0; else f.a_num = 0;
                if ($urandom_range(0, 1)) f.b_den = 0; else f.b_num = 0;
                if ($urandom_range(0, 3) == 0) begin
                    f.a_num = 0;
                    f.a_den = 0;
                end
            end
            SHAPE_SAME: begin
                f.b_num = $urandom_range(0, 1) ? f.a_num : -f.a_num;
                f.b_den = (f.b_num == f.a_num) ? f.a_den : -f.a_den;
            end
        endcase
        return f;
    endfunction

    task automatic send_item(t_field an, t_field ad, t_field bn, t_field bd);
        t_fracs f;
        f.a_num = an;
        f.a_den = ad;
        f.b_num = bn;
        f.b_den = bd;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_a_num    = an;
        i_a_den    = ad;
        i_b_num    = bn;
        i_b_den    = bd;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        equal_expected_q.push_back(predict_equal(f));
        sent_count++;
    endtask

    task automatic pause(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            i_a_num    = t_field'($urandom);
            i_a_den    = t_field'($urandom);
            i_b_num    = t_field'($urandom);
            i_b_den    = t_field'($urandom);
        end
    endtask

    task automatic test_directed();
        stall_mode = STALL_LIGHT;
        send_item(0, 0, 0, 0);
        send_item(0, 0, 0, 5);
        send_item(1, 2, 2, 4);
        send_item(1, 2, -1, -2);
        send_item(-1, 2, 1, -2);
        send_item(3, 0, 7, 0);
        send_item(-3, 0, 5, 0);
        send_item(MIN_F, MIN_F, MIN_F, MIN_F);
        send_item(MIN_F, MIN_F, 1, 1);
        send_item(MIN_F, 1, MIN_F, 1);
        send_item(1, MIN_F, -1, MIN_F);
        send_item(1, MIN_F, 1, MIN_F);
        send_item(MIN_F, 0, MIN_F, 0);
        send_item(MIN_F, 0, 1, 0);
        send_item(0, MIN_F, 0, 1);
        send_item(MAX_F, MAX_F, 1, 1);
        send_item(MAX_F, -MAX_F, -1, 1);
        send_item(6, MIN_F, 3, 32'shc000_0000);
        send_item(-1, -1, 1, 1);
        send_item(MAX_F, MIN_F, MIN_F, MAX_F);
        send_item(12, -18, -2, 3);
        send_item(32'sh4000_0000, MIN_F, -1, 2);
        pause(1);
    endtask

    task automatic test_random(int count, t_stall_mode mode, int max_gap);
        t_fracs f;
        int     burst;
        stall_mode = mode;
        while (count > 0) begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && count > 0) begin
                f = random_fracs();
                send_item(f.a_num, f.a_den, f.b_num, f.b_den);
                burst--;
                count--;
            end
            pause($urandom_range(0, max_gap));
        end
        pause(1);
    endtask

    task automatic test_backpressure();
        t_fracs f;
        stall_mode = STALL_NONE;
        hold_seq++;
        repeat (6) begin
            f = random_fracs();
            send_item(f.a_num, f.a_den, f.b_num, f.b_den);
        end
        pause(1);
    endtask

    initial begin : result_receiver
        int run_left;
        int hold_left;
        int seen_hold;
        run_left    = 0;
        hold_left   = 0;
        seen_hold   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seq != seen_hold) begin
                seen_hold = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else if (run_left > 0) begin
                run_left--;
            end else begin
                run_left = $urandom_range(0, 7);
                case (stall_mode)
                    STALL_NONE:  i_out_stall = 1'b0;
                    STALL_LIGHT: i_out_stall = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_out_stall = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        bit equal_exp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (equal_expected_q.size() == 0) begin
                $error("equal: no result expected, actual %0b", o_equal);
                fail_count++;
            end else begin
                equal_exp = equal_expected_q.pop_front();
                if (o_equal !== equal_exp) begin
                    $error("equal: expected %0b, actual %0b", equal_exp, o_equal);
                    fail_count++;
                end
                if (equal_exp) equal_seen++; else unequal_seen++;
            end
        end
    end

    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        fail_count   = 0;
        sent_count   = 0;
        equal_seen   = 0;
        unequal_seen = 0;
        hold_seq     = 0;
        stall_mode   = STALL_NONE;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_a_num      = '0;
        i_a_den      = '0;
        i_b_num      = '0;
        i_b_den      = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(150, STALL_LIGHT, 6);
        test_backpressure();
        test_random(150, STALL_HEAVY, 20);
        test_random(150, STALL_NONE, 0);

        while (equal_expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d fraction pairs: directed corners, scaled and near-miss pairs,",
                 sent_count);
        $display("zero and extreme operands, noise, and a long output hold; %0d equal, %0d not.",
                 equal_seen, unequal_seen);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
